// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the chorus RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define CHMD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("chorus assertion failed");

// Condition that must never be seen at a clock edge out of reset.
`define CHMD_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("chorus forbidden condition seen");

`endif

// ===== hw/rtl/chmd_pkg.sv =====
// Shared types and constants for the chorus modulated delay.
// No dependencies; used by every module of the block.
package chmd_pkg;

  localparam int SampleW  = 24;
  localparam int BaseW    = 12;
  localparam int RateW    = 16;
  localparam int PhaseW   = 16;
  localparam int DelayW   = 13;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [BaseW-1:0]  BaseRst = 12'd720;
  // Phase step that belongs to the reset rate of one.
  localparam logic [PhaseW-1:0] StepRst = 16'd1;

  // step = rate * 65536 / 48000 = rate * 512 / 375, done as a multiply by
  // ceil(2^34 / 375) and a shift; exact for every 16-bit rate.
  localparam logic [25:0] RateRecip = 26'd45812985;
  localparam int          RateShift = 25;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE     = 2'd0,
    REG_BASE_DELAY = 2'd1,
    REG_LFO_RATE   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic              enable;
    logic [BaseW-1:0]  base_delay;
    logic [PhaseW-1:0] phase_step;
  } chmd_cfg_t;

  typedef struct packed {
    logic                      en;
    logic signed [SampleW-1:0] dry;
    logic signed [SampleW-1:0] wet;
  } chmd_item_t;

endpackage

// ===== hw/rtl/chmd_front.sv =====
// Front end: takes samples, runs the LFO and delay arithmetic, owns the delay line.
// Depends on chmd_pkg and assert_macros.svh.
module chmd_front
  import chmd_pkg::*;
#(
  parameter int DELAY_DEPTH = 1440,
  parameter int LFO_SCALE   = 32,
  parameter int MIN_DELAY   = 240,
  parameter int MAX_DELAY   = 1400
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  chmd_cfg_t                 cfg_i,
  input  logic                      in_valid_i,
  input  logic signed [SampleW-1:0] in_sample_i,
  output logic                      item_valid_o,
  output chmd_item_t                item_o
);

  localparam int HeadW = $clog2(DELAY_DEPTH);
  localparam logic [HeadW-1:0] HeadLast = HeadW'(DELAY_DEPTH - 1);
  localparam longint unsigned Recip =
      ((64'd1 << (2 * DelayW)) + DELAY_DEPTH - 1) / DELAY_DEPTH;
  localparam int RecipW = $clog2(Recip + 1);
  localparam int QuotW  = $clog2((1 << DelayW) / DELAY_DEPTH + 1);
  localparam logic signed [9:0]  ModS = 10'(LFO_SCALE);
  localparam logic signed [13:0] MinS = 14'(MIN_DELAY);
  localparam logic signed [13:0] MaxS = 14'(MAX_DELAY);

  // Running state, advanced only by enabled samples.
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [HeadW-1:0]  head_q, head_d;
  logic              full_q, full_d;
  logic              take;

  // Pipeline: valid bits are control, the rest is payload.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1_q, en2_q, en3_q, en4_q, en5_q, en6_q;
  logic full1_q, full2_q, full3_q, full4_q, full5_q;
  logic signed [SampleW-1:0] x1_q, x2_q, x3_q, x4_q, x5_q, x6_q;
  logic [HeadW-1:0] head1_q, head2_q, head3_q, head4_q, head5_q;
  logic [PhaseW-1:0] phase1_q;
  logic signed [9:0] scaled2_q, scaled2_d;
  logic [DelayW-1:0] delay3_q, delay3_d, delay4_q;
  logic [QuotW-1:0]  quot4_q, quot4_d;
  logic [HeadW-1:0]  dmod5_q, dmod5_d;
  logic              wv6_q, wv6_d;

  logic [SampleW-1:0] mem_q [DELAY_DEPTH];
  logic [SampleW-1:0] rdata_q;

  assign take    = in_valid_i & cfg_i.enable;
  assign phase_d = phase_q + cfg_i.phase_step;
  assign head_d  = (head_q == HeadLast) ? '0 : head_q + 1'b1;
  assign full_d  = full_q | (head_q == HeadLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      head_q  <= '0;
      full_q  <= 1'b0;
    end else if (take) begin
      phase_q <= phase_d;
      head_q  <= head_d;
      full_q  <= full_d;
    end
  end

  // Triangle LFO from the top ten phase bits, then the depth scaling.
  logic [9:0]         ph_top;
  logic [10:0]        ramp;
  logic signed [12:0] lfo_raw;
  logic signed [9:0]  lfo_c;
  logic signed [19:0] lfo_prod;

  always_comb begin
    ph_top  = phase1_q[PhaseW-1:6];
    ramp    = ph_top[9] ? (11'd1024 - {1'b0, ph_top}) : {1'b0, ph_top};
    lfo_raw = signed'({1'b0, ramp, 1'b0}) - 13'sd512;
    priority if (lfo_raw > 13'sd256) begin
      lfo_c = 10'sd256;
    end else if (lfo_raw < -13'sd256) begin
      lfo_c = -10'sd256;
    end else begin
      lfo_c = 10'(lfo_raw);
    end
    lfo_prod  = lfo_c * ModS;
    scaled2_d = 10'(lfo_prod >>> 8);
  end

  // Base plus modulation, lower bound first so that the upper one wins.
  logic signed [13:0] dsum;
  logic signed [13:0] dclamp;

  always_comb begin
    dsum   = signed'({2'b00, cfg_i.base_delay}) + 14'(scaled2_q);
    dclamp = dsum;
    if (dclamp < MinS) begin
      dclamp = MinS;
    end
    if (dclamp > MaxS) begin
      dclamp = MaxS;
    end
    delay3_d = DelayW'(dclamp);
  end

  // Delay reduced modulo the line length: reciprocal quotient, then remainder.
  logic [DelayW+RecipW-1:0] qprod;
  logic [DelayW-1:0]        qtimes;

  assign qprod   = (DelayW + RecipW)'(delay3_q) * (DelayW + RecipW)'(Recip);
  assign quot4_d = QuotW'(qprod >> (2 * DelayW));
  assign qtimes  = DelayW'(quot4_q) * DelayW'(DELAY_DEPTH);
  assign dmod5_d = HeadW'(delay4_q - qtimes);

  // Read position behind the write head; an entry is live once written.
  logic [HeadW:0]   diff;
  logic             wrapped;
  logic [HeadW-1:0] rd_addr;

  always_comb begin
    diff    = {1'b0, head5_q} - {1'b0, dmod5_q};
    wrapped = diff[HeadW];
    rd_addr = wrapped ? HeadW'(diff + (HeadW + 1)'(DELAY_DEPTH)) : diff[HeadW-1:0];
    wv6_d   = full5_q | (!wrapped && (dmod5_q != '0));
  end

  always_ff @(posedge clk_i) begin
    if (v5_q && en5_q) begin
      mem_q[head5_q] <= x5_q;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    en1_q     <= cfg_i.enable;
    x1_q      <= in_sample_i;
    phase1_q  <= phase_d;
    head1_q   <= head_q;
    full1_q   <= full_q;

    en2_q     <= en1_q;
    x2_q      <= x1_q;
    head2_q   <= head1_q;
    full2_q   <= full1_q;
    scaled2_q <= scaled2_d;

    en3_q     <= en2_q;
    x3_q      <= x2_q;
    head3_q   <= head2_q;
    full3_q   <= full2_q;
    delay3_q  <= delay3_d;

    en4_q     <= en3_q;
    x4_q      <= x3_q;
    head4_q   <= head3_q;
    full4_q   <= full3_q;
    delay4_q  <= delay3_q;
    quot4_q   <= quot4_d;

    en5_q     <= en4_q;
    x5_q      <= x4_q;
    head5_q   <= head4_q;
    full5_q   <= full4_q;
    dmod5_q   <= dmod5_d;

    en6_q     <= en5_q;
    x6_q      <= x5_q;
    wv6_q     <= wv6_d;
  end

  assign item_valid_o = v6_q;
  assign item_o.en    = en6_q;
  assign item_o.dry   = x6_q;
  assign item_o.wet   = wv6_q ? signed'(rdata_q) : '0;

  `include "assert_macros.svh"

  `CHMD_ASSERT(a_head_in_range, head_q <= HeadLast)
  `CHMD_ASSERT(a_remainder_in_range, v5_q |-> (dmod5_q <= HeadLast))

endmodule

// ===== hw/rtl/chmd_queue.sv =====
// Short queue of finished front-end items waiting for the mixer.
// Depends on chmd_pkg and assert_macros.svh.
module chmd_queue
  import chmd_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  chmd_item_t push_item_i,
  input  logic       pop_i,
  output logic       valid_o,
  output chmd_item_t item_o
);

  localparam int PtrW = $clog2(DEPTH);

  chmd_item_t      slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            full;

  assign full    = (count_q == (PtrW + 1)'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `include "assert_macros.svh"

  `CHMD_ASSERT_NEVER(a_no_overflow, push_i && full && !pop_i)
  `CHMD_ASSERT_NEVER(a_no_underflow, pop_i && !valid_o)

endmodule

// ===== hw/rtl/chmd_back.sv =====
// Back end: mixes dry and delayed halves, or passes dry when disabled; holds the result for output.
// Depends on chmd_pkg.
module chmd_back
  import chmd_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  chmd_item_t                q_item_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] out_sample_o
);

  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_sample_q, out_sample_d;

  assign q_pop_o = q_valid_i & (!out_valid_q | out_ready_i);

  // Halves are floored, so their sum always fits the sample width.
  always_comb begin
    if (q_item_i.en) begin
      out_sample_d = (q_item_i.dry >>> 1) + (q_item_i.wet >>> 1);
    end else begin
      out_sample_d = q_item_i.dry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_sample_q <= out_sample_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;

endmodule

// ===== hw/rtl/chorus_modulated_delay.sv =====
// Chorus: triangle-LFO modulated delay line on signed 24-bit samples.
// Path: a sample passes the front pipeline, the queue and the registered mixer output.
// Throughput: one sample per cycle, set by the delay line's single read and write port.
// Input is held off only while the output is stalled and 16 samples wait behind it.
// Reset: enable 0, base delay 720, rate 1, phase and write head 0; the delay line
// reads as zero until written, tracked by a wrap flag, so no clearing pass is needed.
module chorus_modulated_delay
  import chmd_pkg::*;
#(
  parameter int DELAY_DEPTH = 1440,
  parameter int LFO_SCALE   = 32,
  parameter int MIN_DELAY   = 240,
  parameter int MAX_DELAY   = 1400
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,  // [23:0] sample_in
  // Output stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata   // [23:0] sample_out
);

  localparam int QueueDepth = 16;
  localparam int CntW       = $clog2(QueueDepth) + 1;

  // Configuration registers; the rate is kept as its phase step.
  logic              enable_q, enable_d;
  logic [BaseW-1:0]  base_q, base_d;
  logic [PhaseW-1:0] step_q, step_d;
  logic [RateW+25:0] step_prod;
  logic              cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign step_prod   = (RateW + 26)'(cfg_data_i[RateW-1:0]) * (RateW + 26)'(RateRecip);

  always_comb begin
    enable_d = enable_q;
    base_d   = base_q;
    step_d   = step_q;
    if (cfg_write) begin
      unique case (cfg_index_i)
        REG_ENABLE:     enable_d = cfg_data_i[0];
        REG_BASE_DELAY: base_d   = cfg_data_i[BaseW-1:0];
        REG_LFO_RATE:   step_d   = step_prod[RateShift +: PhaseW];
        default:        enable_d = enable_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      base_q   <= BaseRst;
      step_q   <= StepRst;
    end else begin
      enable_q <= enable_d;
      base_q   <= base_d;
      step_q   <= step_d;
    end
  end

  chmd_cfg_t cfg;
  assign cfg.enable     = enable_q;
  assign cfg.base_delay = base_q;
  assign cfg.phase_step = step_q;

  // Credits: samples accepted and not yet popped by the mixer never exceed
  // the queue depth, so the front pipeline never has to stall.
  logic [CntW-1:0] cnt_q;
  logic            in_xfer;
  logic            item_valid;
  chmd_item_t      item;
  logic            q_valid;
  chmd_item_t      q_item;
  logic            q_pop;
  logic signed [SampleW-1:0] out_sample;

  assign s_axis_tready = (cnt_q < CntW'(QueueDepth));
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      unique case ({in_xfer, q_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  chmd_front #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .LFO_SCALE   (LFO_SCALE),
    .MIN_DELAY   (MIN_DELAY),
    .MAX_DELAY   (MAX_DELAY)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_xfer),
    .in_sample_i  (signed'(s_axis_tdata)),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  chmd_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (item_valid),
    .push_item_i (item),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (q_item)
  );

  chmd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (out_sample)
  );

  assign m_axis_tdata = out_sample;

  `include "assert_macros.svh"

  `CHMD_ASSERT(a_credit_bound, cnt_q <= CntW'(QueueDepth))
  `CHMD_ASSERT(a_item_holds_credit, item_valid |-> (cnt_q != '0))

endmodule
